@@ rtl/core/sorted_pair_count_merge_unit_macros.svh @@
// Assertion macros shared by the checker of the sorted pair count merge unit.
`ifndef SORTED_PAIR_COUNT_MERGE_UNIT_MACROS_SVH
`define SORTED_PAIR_COUNT_MERGE_UNIT_MACROS_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define SPCM_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define SPCM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/core/spcm_pkg.sv @@
// Package of the sorted pair count merge unit: widths, codes and state type.
package spcm_pkg;

    localparam int QUEUE_DEPTH_DEF = 16;
    localparam int VERTEX_BITS_DEF = 32;

    localparam int FIELD_W   = 32;
    localparam int S_TDATA_W = 3 * FIELD_W;
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = 3 * FIELD_W;
    localparam int M_TUSER_W = 1;

    localparam int TUSER_CMD_BIT = 0;
    localparam int TUSER_HAS_BIT = 1;
    localparam int TUSER_OVF_BIT = 0;

    localparam logic CMD_LIST_A = 1'b0;
    localparam logic CMD_LIST_B = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_CMP,
        ST_SEND
    } spcm_state_t;

endpackage

@@ rtl/core/sorted_pair_count_merge_unit.sv @@
// Sorted pair count merge unit: two FIFO-queued sorted lists merged by one compare/add unit.
//
//  channel | side   | tdata (low bit up)                     | tlast       | tuser (low bit up)
//  s_*     | input  | src_vertex, dst_vertex, sample_count   | end_of_list | cmd, has_entry
//  m_*     | output | out_src, out_dst, out_count            | is_final    | overflow_seen
//
//  An item with no result passes through accept, head read and compare.
//  Each result adds a send and a further compare; the steps are set by the
//  single compare/add unit behind the registered FIFO read port.
//  s_tready is high only while no item is in work.
//  Reset clears pointers, fill counts and flags; FIFO storage needs no clearing pass.
//  m_tready low holds the current beat; the sequencer waits in the send state.
module sorted_pair_count_merge_unit #(
    parameter int QUEUE_DEPTH = spcm_pkg::QUEUE_DEPTH_DEF,
    parameter int VERTEX_BITS = spcm_pkg::VERTEX_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [spcm_pkg::S_TDATA_W-1:0] s_tdata,  // src_vertex, dst_vertex, sample_count
    input  logic                          s_tlast,
    input  logic [spcm_pkg::S_TUSER_W-1:0] s_tuser,  // cmd, has_entry
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [spcm_pkg::M_TDATA_W-1:0] m_tdata,  // out_src, out_dst, out_count
    output logic                          m_tlast,
    output logic [spcm_pkg::M_TUSER_W-1:0] m_tuser   // overflow_seen
);
    import spcm_pkg::*;

    localparam int PTR_W  = $clog2(QUEUE_DEPTH);
    localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);
    localparam int KEY_W  = 2 * VERTEX_BITS;

    localparam logic [PTR_W-1:0]  PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [FILL_W-1:0] FILL_MAX = FILL_W'(QUEUE_DEPTH);

    spcm_state_t state_reg, state_next;

    logic [KEY_W-1:0]   a_key_mem [QUEUE_DEPTH];
    logic [FIELD_W-1:0] a_cnt_mem [QUEUE_DEPTH];
    logic [KEY_W-1:0]   b_key_mem [QUEUE_DEPTH];
    logic [FIELD_W-1:0] b_cnt_mem [QUEUE_DEPTH];

    logic [KEY_W-1:0]   a_key_rd_reg, b_key_rd_reg;
    logic [FIELD_W-1:0] a_cnt_rd_reg, b_cnt_rd_reg;

    logic [PTR_W-1:0]  a_head_reg, a_head_next, a_tail_reg, a_tail_next;
    logic [PTR_W-1:0]  b_head_reg, b_head_next, b_tail_reg, b_tail_next;
    logic [FILL_W-1:0] a_fill_reg, a_fill_next, b_fill_reg, b_fill_next;
    logic              a_ended_reg, a_ended_next, b_ended_reg, b_ended_next;
    logic              ovf_reg, ovf_next;
    logic              m_tvalid_reg, m_tvalid_next;

    logic [FIELD_W-1:0] out_src_reg, out_src_next;
    logic [FIELD_W-1:0] out_dst_reg, out_dst_next;
    logic [FIELD_W-1:0] out_cnt_reg, out_cnt_next;
    logic               out_last_reg, out_last_next;

    logic               in_acc;
    logic               in_cmd, in_has;
    logic [KEY_W-1:0]   in_key;
    logic [FIELD_W-1:0] in_cnt;
    logic               push_a, push_b;

    logic               fa, fb, both, a_lt, keys_eq;
    logic               pop_a, pop_b, emit, final_emit, marker;
    logic [FIELD_W:0]   sum_wide;
    logic [FIELD_W-1:0] sum_sat;
    logic [KEY_W-1:0]   res_key;
    logic [FIELD_W-1:0] res_cnt;
    logic [FILL_W-1:0]  a_fill_after, b_fill_after;

    // Input beat decode
    assign in_acc = s_tvalid && s_tready;
    assign in_cmd = s_tuser[TUSER_CMD_BIT];
    assign in_has = s_tuser[TUSER_HAS_BIT];
    assign in_key = {s_tdata[VERTEX_BITS-1:0], s_tdata[FIELD_W +: VERTEX_BITS]};
    assign in_cnt = s_tdata[2*FIELD_W +: FIELD_W];

    assign push_a = in_acc && in_has && (in_cmd == CMD_LIST_A) && (a_fill_reg != FILL_MAX);
    assign push_b = in_acc && in_has && (in_cmd == CMD_LIST_B) && (b_fill_reg != FILL_MAX);

    // Shared compare/add unit on the two FIFO heads
    assign fa      = a_fill_reg != '0;
    assign fb      = b_fill_reg != '0;
    assign both    = fa && fb;
    assign a_lt    = a_key_rd_reg < b_key_rd_reg;
    assign keys_eq = a_key_rd_reg == b_key_rd_reg;

    assign pop_a = both ? (a_lt || keys_eq) : (fa && b_ended_reg);
    assign pop_b = both ? !a_lt : (!fa && fb && a_ended_reg);
    assign emit  = pop_a || pop_b;

    assign sum_wide = {1'b0, a_cnt_rd_reg} + {1'b0, b_cnt_rd_reg};
    assign sum_sat  = sum_wide[FIELD_W] ? '1 : sum_wide[FIELD_W-1:0];
    assign res_key  = pop_a ? a_key_rd_reg : b_key_rd_reg;
    assign res_cnt  = (pop_a && pop_b) ? sum_sat : (pop_a ? a_cnt_rd_reg : b_cnt_rd_reg);

    assign a_fill_after = a_fill_reg - FILL_W'(pop_a);
    assign b_fill_after = b_fill_reg - FILL_W'(pop_b);
    assign final_emit   = a_ended_reg && b_ended_reg
                          && (a_fill_after == '0) && (b_fill_after == '0);
    assign marker       = !emit && a_ended_reg && b_ended_reg && !fa && !fb;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                state_next = ST_CMP;
            end
            ST_CMP:
            begin
                if (emit || marker)
                begin
                    state_next = ST_SEND;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_SEND:
            begin
                if (m_tready)
                begin
                    state_next = ST_CMP;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Datapath and queue bookkeeping
    always_comb
    begin
        a_head_next   = a_head_reg;
        a_tail_next   = a_tail_reg;
        a_fill_next   = a_fill_reg;
        b_head_next   = b_head_reg;
        b_tail_next   = b_tail_reg;
        b_fill_next   = b_fill_reg;
        a_ended_next  = a_ended_reg;
        b_ended_next  = b_ended_reg;
        ovf_next      = ovf_reg;
        m_tvalid_next = m_tvalid_reg;
        out_src_next  = out_src_reg;
        out_dst_next  = out_dst_reg;
        out_cnt_next  = out_cnt_reg;
        out_last_next = out_last_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    if (push_a)
                    begin
                        a_tail_next = (a_tail_reg == PTR_LAST) ? '0 : a_tail_reg + PTR_W'(1);
                        a_fill_next = a_fill_reg + FILL_W'(1);
                    end
                    if (push_b)
                    begin
                        b_tail_next = (b_tail_reg == PTR_LAST) ? '0 : b_tail_reg + PTR_W'(1);
                        b_fill_next = b_fill_reg + FILL_W'(1);
                    end
                    if (in_has && !push_a && !push_b)
                    begin
                        ovf_next = 1'b1;
                    end
                    if (s_tlast && (in_cmd == CMD_LIST_A))
                    begin
                        a_ended_next = 1'b1;
                    end
                    if (s_tlast && (in_cmd == CMD_LIST_B))
                    begin
                        b_ended_next = 1'b1;
                    end
                end
            end
            ST_CMP:
            begin
                if (emit)
                begin
                    out_src_next  = FIELD_W'(res_key[KEY_W-1 -: VERTEX_BITS]);
                    out_dst_next  = FIELD_W'(res_key[VERTEX_BITS-1:0]);
                    out_cnt_next  = res_cnt;
                    out_last_next = final_emit;
                    m_tvalid_next = 1'b1;
                    a_fill_next   = a_fill_after;
                    b_fill_next   = b_fill_after;
                    if (pop_a)
                    begin
                        a_head_next = (a_head_reg == PTR_LAST) ? '0 : a_head_reg + PTR_W'(1);
                    end
                    if (pop_b)
                    begin
                        b_head_next = (b_head_reg == PTR_LAST) ? '0 : b_head_reg + PTR_W'(1);
                    end
                    if (final_emit)
                    begin
                        a_ended_next = 1'b0;
                        b_ended_next = 1'b0;
                    end
                end
                else if (marker)
                begin
                    out_src_next  = '0;
                    out_dst_next  = '0;
                    out_cnt_next  = '0;
                    out_last_next = 1'b1;
                    m_tvalid_next = 1'b1;
                    a_ended_next  = 1'b0;
                    b_ended_next  = 1'b0;
                end
            end
            ST_SEND:
            begin
                if (m_tready)
                begin
                    m_tvalid_next = 1'b0;
                end
            end
            default:
            begin
                m_tvalid_next = m_tvalid_reg;
            end
        endcase
    end

    // Outputs
    always_comb
    begin
        s_tready = (state_reg == ST_IDLE);
        m_tvalid = m_tvalid_reg;
        m_tdata  = {out_cnt_reg, out_dst_reg, out_src_reg};
        m_tlast  = out_last_reg;
        m_tuser  = M_TUSER_W'(ovf_reg);
    end

    // FIFO storage: write at tail on push, registered read at head every cycle
    always_ff @(posedge clk)
    begin
        if (push_a)
        begin
            a_key_mem[a_tail_reg] <= in_key;
            a_cnt_mem[a_tail_reg] <= in_cnt;
        end
        if (push_b)
        begin
            b_key_mem[b_tail_reg] <= in_key;
            b_cnt_mem[b_tail_reg] <= in_cnt;
        end
        a_key_rd_reg <= a_key_mem[a_head_reg];
        a_cnt_rd_reg <= a_cnt_mem[a_head_reg];
        b_key_rd_reg <= b_key_mem[b_head_reg];
        b_cnt_rd_reg <= b_cnt_mem[b_head_reg];
    end

    // Output payload
    always_ff @(posedge clk)
    begin
        out_src_reg  <= out_src_next;
        out_dst_reg  <= out_dst_next;
        out_cnt_reg  <= out_cnt_next;
        out_last_reg <= out_last_next;
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            a_head_reg   <= '0;
            a_tail_reg   <= '0;
            a_fill_reg   <= '0;
            b_head_reg   <= '0;
            b_tail_reg   <= '0;
            b_fill_reg   <= '0;
            a_ended_reg  <= 1'b0;
            b_ended_reg  <= 1'b0;
            ovf_reg      <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            a_head_reg   <= a_head_next;
            a_tail_reg   <= a_tail_next;
            a_fill_reg   <= a_fill_next;
            b_head_reg   <= b_head_next;
            b_tail_reg   <= b_tail_next;
            b_fill_reg   <= b_fill_next;
            a_ended_reg  <= a_ended_next;
            b_ended_reg  <= b_ended_next;
            ovf_reg      <= ovf_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

endmodule

@@ rtl/core/spcm_checker.sv @@
// Port checker of the sorted pair count merge unit, bound to the top level.
`include "sorted_pair_count_merge_unit_macros.svh"

module spcm_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          s_tvalid,
    input logic                          s_tready,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [spcm_pkg::M_TDATA_W-1:0] m_tdata,  // out_src, out_dst, out_count
    input logic                          m_tlast,
    input logic [spcm_pkg::M_TUSER_W-1:0] m_tuser   // overflow_seen
);
    import spcm_pkg::*;

    // Hold a stalled output beat
    `SPCM_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tlast) && $stable(m_tuser), "stalled output beat changed")

    // Never take a new item while a result waits
    `SPCM_ASSERT_SAME(a_one_item, m_tvalid, !s_tready, "input ready while output beat pending")

    // Drop ready after an accepted beat
    `SPCM_ASSERT_NEXT(a_busy_after_acc, s_tvalid && s_tready, !s_tready, "ready right after accept")

    // Keep the overflow flag once set
    `SPCM_ASSERT_NEXT(a_ovf_sticky, m_tuser[TUSER_OVF_BIT], m_tuser[TUSER_OVF_BIT], "overflow flag cleared")

endmodule

bind sorted_pair_count_merge_unit spcm_checker u_spcm_checker (.*);

@@ verif/tb.sv @@
// Self-checking testbench for the sorted pair count merge unit.
module tb;
    import spcm_pkg::*;

    localparam int QDEPTH      = QUEUE_DEPTH_DEF;
    localparam int HOLD_CYCLES = 300;
    localparam int WATCHDOG    = 2000;
    localparam int RAND_TARGET = 355;

    typedef struct {
        logic [FIELD_W-1:0] src;
        logic [FIELD_W-1:0] dst;
        logic [FIELD_W-1:0] cnt;
        logic               is_final;
        logic               ovf;
    } merged_entry_t;

    logic                 clk;
    logic                 rst_n;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata;   // src_vertex, dst_vertex, sample_count
    logic                 s_tlast;
    logic [S_TUSER_W-1:0] s_tuser;   // cmd, has_entry
    logic                 m_tvalid;
    logic                 m_tready;
    logic [M_TDATA_W-1:0] m_tdata;   // out_src, out_dst, out_count
    logic                 m_tlast;
    logic [M_TUSER_W-1:0] m_tuser;   // overflow_seen

    logic [63:0]        list_a_keys[$];
    logic [FIELD_W-1:0] list_a_cnts[$];
    logic [63:0]        list_b_keys[$];
    logic [FIELD_W-1:0] list_b_cnts[$];
    bit                 a_ended;
    bit                 b_ended;
    bit                 drop_seen;

    merged_entry_t pending_merge_q[$];

    bit idle_on  = 1'b1;
    bit hold_req = 1'b0;
    int err_count;
    int items_sent;
    int beats_checked;
    int list_ends;
    int saturated_sums;
    int stall_cycles;

    sorted_pair_count_merge_unit DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    initial clk = 1'b0;
    always #6 clk = ~clk;

    function automatic merged_entry_t make_entry(logic [63:0] key, logic [FIELD_W-1:0] cnt);
        merged_entry_t e;
        e.src      = key[63:32];
        e.dst      = key[31:0];
        e.cnt      = cnt;
        e.is_final = 1'b0;
        e.ovf      = 1'b0;
        return e;
    endfunction

    function automatic void merge_predict(logic cmd, logic has, logic eol,
                                          logic [FIELD_W-1:0] src, logic [FIELD_W-1:0] dst,
                                          logic [FIELD_W-1:0] cnt);
        logic [63:0]   key;
        logic [32:0]   sum;
        merged_entry_t outs[$];
        key = {src, dst};
        if (has)
        begin
            if (cmd == CMD_LIST_A)
            begin
                if (list_a_keys.size() >= QDEPTH)
                    drop_seen = 1'b1;
                else
                begin
                    list_a_keys.insert(list_a_keys.size(), key);
                    list_a_cnts.insert(list_a_cnts.size(), cnt);
                end
            end
            else
            begin
                if (list_b_keys.size() >= QDEPTH)
                    drop_seen = 1'b1;
                else
                begin
                    list_b_keys.insert(list_b_keys.size(), key);
                    list_b_cnts.insert(list_b_cnts.size(), cnt);
                end
            end
        end
        if (eol)
        begin
            if (cmd == CMD_LIST_A)
                a_ended = 1'b1;
            else
                b_ended = 1'b1;
        end
        while (1)
        begin
            if (list_a_keys.size() > 0 && list_b_keys.size() > 0)
            begin
                if (list_a_keys[0] < list_b_keys[0])
                    outs.insert(outs.size(),
                                make_entry(list_a_keys.pop_front(), list_a_cnts.pop_front()));
                else if (list_b_keys[0] < list_a_keys[0])
                    outs.insert(outs.size(),
                                make_entry(list_b_keys.pop_front(), list_b_cnts.pop_front()));
                else
                begin
                    sum = {1'b0, list_a_cnts.pop_front()} + {1'b0, list_b_cnts.pop_front()};
                    if (sum[32])
                        saturated_sums++;
                    outs.insert(outs.size(), make_entry(list_a_keys.pop_front(),
                                                        sum[32] ? '1 : sum[31:0]));
                    void'(list_b_keys.pop_front());
                end
            end
            else if (list_a_keys.size() > 0 && b_ended)
                outs.insert(outs.size(),
                            make_entry(list_a_keys.pop_front(), list_a_cnts.pop_front()));
            else if (list_b_keys.size() > 0 && a_ended)
                outs.insert(outs.size(),
                            make_entry(list_b_keys.pop_front(), list_b_cnts.pop_front()));
            else
                break;
        end
        if (a_ended && b_ended && list_a_keys.size() == 0 && list_b_keys.size() == 0)
        begin
            if (outs.size() == 0)
                outs.insert(outs.size(), make_entry('0, '0));
            outs[outs.size()-1].is_final = 1'b1;
            a_ended = 1'b0;
            b_ended = 1'b0;
            list_ends++;
        end
        foreach (outs[i])
        begin
            outs[i].ovf = drop_seen;
            pending_merge_q.insert(pending_merge_q.size(), outs[i]);
        end
    endfunction

    function automatic logic [FIELD_W-1:0] random_count();
        case ($urandom_range(0, 7))
            0:       return 32'hFFFF_FFFF - $urandom_range(0, 15);
            1:       return $urandom_range(0, 3);
            default: return $urandom;
        endcase
    endfunction

    function automatic void check_field(string name, logic [FIELD_W-1:0] want,
                                        logic [FIELD_W-1:0] got);
        if (got !== want)
        begin
            $error("%s: expected %h, got %h", name, want, got);
            err_count++;
        end
    endfunction

    task automatic send_item(input logic cmd, input logic has, input logic eol,
                             input logic [FIELD_W-1:0] src, input logic [FIELD_W-1:0] dst,
                             input logic [FIELD_W-1:0] cnt);
        int                   gap;
        logic [S_TUSER_W-1:0] user;
        @(negedge clk);
        if (idle_on && $urandom_range(0, 4) == 0)
        begin
            gap = $urandom_range(1, 9);
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        user                = '0;
        user[TUSER_CMD_BIT] = cmd;
        user[TUSER_HAS_BIT] = has;
        s_tdata  <= {cnt, dst, src};
        s_tuser  <= user;
        s_tlast  <= eol;
        s_tvalid <= 1'b1;
        do @(posedge clk); while (!s_tready);
        merge_predict(cmd, has, eol, src, dst, cnt);
        items_sent++;
    endtask

    task automatic send_end(input logic cmd);
        send_item(cmd, 1'b0, 1'b1, $urandom, $urandom, $urandom);
    endtask

    task automatic wait_drain();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (pending_merge_q.size() > 0) @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    // close out any half-finished pair of lists
    task automatic settle_lists();
        while (a_ended || b_ended || list_a_keys.size() > 0 || list_b_keys.size() > 0)
            send_end(a_ended ? CMD_LIST_B : CMD_LIST_A);
    endtask

    task automatic run_list_pair(input int n_keys, input bit narrow, input bit broken);
        logic [63:0]        pool[$];
        logic [63:0]        la[$];
        logic [63:0]        lb[$];
        logic [FIELD_W-1:0] ca[$];
        logic [FIELD_W-1:0] cb[$];
        logic [63:0]        tmp;
        int                 m;
        bit                 sep_a;
        bit                 sep_b;
        int                 na;
        int                 nb;
        int                 sa;
        int                 sb;
        repeat (n_keys)
        begin
            if (narrow)
                pool.insert(pool.size(),
                            {32'($urandom_range(0, 3)), 32'($urandom_range(0, 7))});
            else
                pool.insert(pool.size(), {$urandom, $urandom});
        end
        pool.sort();
        foreach (pool[i])
        begin
            m = $urandom_range(0, 2);
            if (m != 1)
            begin
                la.insert(la.size(), pool[i]);
                ca.insert(ca.size(), random_count());
            end
            if (m != 0)
            begin
                lb.insert(lb.size(), pool[i]);
                cb.insert(cb.size(), random_count());
            end
        end
        if (broken && la.size() > 1)
        begin
            tmp            = la[0];
            la[0]          = la[la.size()-1];
            la[la.size()-1] = tmp;
        end
        sep_a = (la.size() == 0) || ($urandom_range(0, 1) == 0);
        sep_b = (lb.size() == 0) || ($urandom_range(0, 1) == 0);
        na    = la.size() + sep_a;
        nb    = lb.size() + sep_b;
        sa    = 0;
        sb    = 0;
        while (sa < na || sb < nb)
        begin
            if (sb >= nb || (sa < na && $urandom_range(0, 1) == 0))
            begin
                if (sa < la.size())
                    send_item(CMD_LIST_A, 1'b1, !sep_a && sa == la.size() - 1,
                              la[sa][63:32], la[sa][31:0], ca[sa]);
                else
                    send_end(CMD_LIST_A);
                sa++;
            end
            else
            begin
                if (sb < lb.size())
                    send_item(CMD_LIST_B, 1'b1, !sep_b && sb == lb.size() - 1,
                              lb[sb][63:32], lb[sb][31:0], cb[sb]);
                else
                    send_end(CMD_LIST_B);
                sb++;
            end
            if (broken && $urandom_range(0, 5) == 0)
                send_end(1'($urandom_range(0, 1)));
        end
    endtask

    task automatic test_basic_merge();
        send_item(CMD_LIST_A, 1'b1, 1'b0, 32'd0, 32'd0, 32'd1);
        send_item(CMD_LIST_B, 1'b1, 1'b0, 32'd0, 32'd0, 32'd2);
        send_item(CMD_LIST_A, 1'b1, 1'b0, 32'd5, 32'd9, 32'd10);
        send_item(CMD_LIST_B, 1'b1, 1'b0, 32'd5, 32'd8, 32'd11);
        send_item(CMD_LIST_B, 1'b1, 1'b0, 32'd5, 32'd9, 32'hFFFF_FFFF);
        send_item(CMD_LIST_A, 1'b1, 1'b0, 32'd7, 32'd1, 32'hFFFF_FFF0);
        send_item(CMD_LIST_B, 1'b1, 1'b0, 32'd7, 32'd1, 32'h0000_000F);
        send_item(CMD_LIST_A, 1'b1, 1'b1, 32'hFFFF_FFFF, 32'd0, 32'd0);
        send_item(CMD_LIST_B, 1'b1, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        wait_drain();
    endtask

    task automatic test_end_marker();
        send_end(CMD_LIST_A);
        send_end(CMD_LIST_B);
        send_end(CMD_LIST_B);
        send_end(CMD_LIST_A);
        wait_drain();
    endtask

    task automatic test_entries_after_end();
        send_end(CMD_LIST_A);
        send_item(CMD_LIST_A, 1'b1, 1'b0, 32'd3, 32'd3, 32'd4);
        send_end(CMD_LIST_A);
        send_item(CMD_LIST_B, 1'b1, 1'b1, 32'd3, 32'd3, 32'd6);
        wait_drain();
    endtask

    task automatic test_unsorted_heads();
        send_item(CMD_LIST_A, 1'b1, 1'b0, 32'd9, 32'd9, 32'd1);
        send_item(CMD_LIST_A, 1'b1, 1'b0, 32'd1, 32'd1, 32'd2);
        send_item(CMD_LIST_B, 1'b1, 1'b0, 32'd4, 32'd4, 32'd3);
        send_end(CMD_LIST_B);
        send_end(CMD_LIST_A);
        wait_drain();
    endtask

    task automatic test_backpressure();
        hold_req = 1'b1;
        run_list_pair(12, 1'b0, 1'b0);
        wait_drain();
    endtask

    task automatic test_random_merge();
        while (items_sent < RAND_TARGET)
        begin
            if ($urandom_range(0, 3) != 0)
                settle_lists();
            if ($urandom_range(0, 3) == 0)
                send_item(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                          $urandom_range(0, 3) == 0, $urandom, $urandom, random_count());
            run_list_pair($urandom_range(0, 12), $urandom_range(0, 2) == 0,
                          $urandom_range(0, 7) == 0);
        end
        wait_drain();
    endtask

    task automatic test_fifo_overflow();
        idle_on = 1'b0;
        settle_lists();
        send_end(CMD_LIST_A);
        for (int i = 0; i < QDEPTH + 2; i++)
            send_item(CMD_LIST_A, 1'b1, 1'b0, 32'(i + 1), $urandom, random_count());
        send_item(CMD_LIST_B, 1'b1, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, random_count());
        wait_drain();
    endtask

    initial
    begin : sink_ready
        int n;
        bit hold_done;
        m_tready  = 1'b0;
        hold_done = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_req && !hold_done)
            begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES)
                begin
                    @(negedge clk);
                    stall_cycles++;
                end
                m_tready <= 1'b1;
                hold_done = 1'b1;
            end
            else if (idle_on && $urandom_range(0, 5) == 0)
            begin
                n = $urandom_range(1, 9);
                m_tready <= 1'b0;
                repeat (n) @(negedge clk);
                m_tready <= 1'b1;
            end
            else
                m_tready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin : merge_check
        merged_entry_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_merge_q.size() == 0)
            begin
                $error("unexpected beat: src %h dst %h count %h",
                       m_tdata[FIELD_W-1:0], m_tdata[2*FIELD_W-1:FIELD_W],
                       m_tdata[3*FIELD_W-1:2*FIELD_W]);
                err_count++;
            end
            else
            begin
                want = pending_merge_q.pop_front();
                check_field("out_src", want.src, m_tdata[FIELD_W-1:0]);
                check_field("out_dst", want.dst, m_tdata[2*FIELD_W-1:FIELD_W]);
                check_field("out_count", want.cnt, m_tdata[3*FIELD_W-1:2*FIELD_W]);
                check_field("is_final", FIELD_W'(want.is_final), FIELD_W'(m_tlast));
                check_field("overflow_seen", FIELD_W'(want.ovf),
                            FIELD_W'(m_tuser[TUSER_OVF_BIT]));
            end
            beats_checked++;
        end
    end

    always @(posedge clk)
    begin : watchdog
        int quiet;
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet = 0;
        else
        begin
            quiet++;
            if (quiet == WATCHDOG)
            begin
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    initial
    begin
        rst_n    = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tlast  = 1'b0;
        s_tuser  = '0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        test_basic_merge();
        test_end_marker();
        test_entries_after_end();
        test_unsorted_heads();
        test_backpressure();
        test_random_merge();
        test_fifo_overflow();
        $display("Merged %0d items into %0d checked beats: %0d list ends, %0d saturated sums,",
                 items_sent, beats_checked, list_ends, saturated_sums);
        $display("a %0d-cycle output hold and a dropped push on a full queue.", stall_cycles);
        if (err_count == 0 && pending_merge_q.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
